FILE: rtl/crth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crth_pkg
// Shared types and constants of the closest ray/triangle hit core.
// ----------------------------------------------------------------------------
package crth_pkg;

   localparam int MAX_TRIS = 256;
   localparam int TRI_W    = $clog2(MAX_TRIS);
   localparam int SLOT_W   = 2;
   localparam int ADDR_W   = TRI_W + SLOT_W;
   localparam int CW       = 32;
   localparam int FRAC     = 16;
   localparam int VW       = CW + 1;
   localparam int MW       = 35;
   localparam int PW       = 2 * MW;
   localparam int CRW      = 68;
   localparam int CRLO     = 34;
   localparam int DW       = 104;
   localparam int RW       = DW + 1;
   localparam int QW       = CW - 1;
   localparam int CNT_W    = TRI_W + 1;
   localparam int ROW_W    = 3 * CW;

   localparam logic [QW-1:0]    TMAX      = '1;
   localparam logic [CNT_W-1:0] TRI_LIMIT = CNT_W'(MAX_TRIS);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TRACE = 1'b1;

   localparam logic [1:0] CSR_COUNT = 2'd0;
   localparam logic [1:0] CSR_ORG_X = 2'd1;
   localparam logic [1:0] CSR_ORG_Y = 2'd2;
   localparam logic [1:0] CSR_ORG_Z = 2'd3;

   localparam logic [SLOT_W-1:0] SLOT_NONE = 2'd3;

   localparam logic [CW-1:0] ORG_Z_RST = CW'(-(64'sd2 <<< FRAC));

   typedef logic [2:0][CW-1:0] vec3_type;
   typedef logic [2:0][VW-1:0] v33_type;
   typedef logic [2:0][CRW-1:0] cr3_type;

   typedef struct packed {
      logic             start;
      vec3_type         dir;
      vec3_type         org;
      logic [CNT_W-1:0] count;
   } trace_type;

   typedef struct packed {
      logic [QW-1:0]    hit_dist;
      logic [CW-1:0]    pos_z;
      logic [CW-1:0]    pos_y;
      logic [CW-1:0]    pos_x;
      logic [QW-1:0]    hit_param;
      logic [TRI_W-1:0] hit_tri;
      logic             hit;
   } res_type;

   typedef enum logic [3:0] {
      E_IDLE, E_LOAD, E_CROSS, E_DOT, E_NORM, E_TEST, E_DIV, E_NEXT, E_FIN, E_OUT
   } eng_state_type;

   function automatic logic [1:0] idx_next(input logic [1:0] j);
      logic [1:0] r;
      case (j)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] idx_prev(input logic [1:0] j);
      logic [1:0] r;
      case (j)
         2'd0:    r = 2'd2;
         2'd1:    r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/closest_ray_triangle_hit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_ray_triangle_hit_core
// Closest-hit search of one ray against a table of up to 256 triangles.
// ----------------------------------------------------------------------------
// Requests arrive on req_*: tuser 0 writes one vertex (x, y, z) of a triangle
// (vertex slot 3 writes nothing) and gives no response; tuser 1 traces a ray
// from the origin registers along the request's direction and gives one
// response on rsp_*. A trace walks triangles 0 .. triangle_count-1 one at a
// time on a single shared 35x35 multiplier: vertex fetch, cross products,
// determinants, checks, a restoring divide for t unless the checks fail or t
// saturates, then the pick. For a hit, position and distance follow once the
// length root finishes. One request is worked at a time; req_tready is high
// while the engine is idle. A finished response waits in the rsp_* register,
// and the next request is taken while it waits; a further response stalls
// the engine until rsp_tready drains the register. Reset clears the control
// state and loads the csr defaults; the vertex table is not cleared and must
// be written before it is searched. csr writes are registered; a running
// trace keeps the values that it took at its start.
// ----------------------------------------------------------------------------
module closest_ray_triangle_hit_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tri_index[7:0], vertex_slot[9:8], vert_x[41:10], vert_y[73:42],
   // vert_z[105:74], dir_x[137:106], dir_y[169:138], dir_z[201:170]
   input  logic [207:0] req_tdata,
   // op
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit[0], hit_tri[8:1], hit_param[39:9], pos_x[71:40], pos_y[103:72],
   // pos_z[135:104], hit_dist[166:136]
   output logic [167:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);
   import crth_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   vec3_type         org_ff, org_in;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_data_ff, rsp_data_in;

   trace_type         trc;
   logic              take, eng_idle, eng_valid, accept;
   res_type           eng_res;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [ROW_W-1:0]  wr_data, rd_data;
   logic [SLOT_W-1:0] slot;

   assign req_tready = eng_idle;
   assign accept     = req_tvalid && req_tready;
   assign slot       = req_tdata[9:8];
   assign wr_en      = accept && (req_tuser == OP_WRITE) && (slot != SLOT_NONE);
   assign wr_addr    = {req_tdata[TRI_W-1:0], slot};
   assign wr_data    = req_tdata[105:10];

   assign trc.start = accept && (req_tuser == OP_TRACE);
   assign trc.dir   = vec3_type'(req_tdata[201:106]);
   assign trc.org   = org_ff;
   assign trc.count = count_ff;

   assign take = eng_valid && (!rsp_valid_ff || rsp_tready);

   crth_vtx_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   crth_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .trc       (trc),
      .take      (take),
      .idle      (eng_idle),
      .res_valid (eng_valid),
      .res       (eng_res),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      org_in   = org_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_COUNT: count_in  = csr_wdata[CNT_W-1:0];
            CSR_ORG_X: org_in[0] = csr_wdata;
            CSR_ORG_Y: org_in[1] = csr_wdata;
            CSR_ORG_Z: org_in[2] = csr_wdata;
            default:   count_in  = count_ff;
         endcase
      end
      rsp_data_in  = take ? eng_res : rsp_data_ff;
      rsp_valid_in = take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         org_ff       <= {ORG_Z_RST, 32'h0, 32'h0};
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         org_ff       <= org_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[167:1] == '0)
      else $error("miss response carries nonzero fields");

   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> {1'b0, rsp_tdata[8:1]} < count_ff)
      else $error("hit triangle beyond searched count");

   a_zero_t_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] && rsp_tdata[39:9] == '0 |-> rsp_tdata[166:136] == '0)
      else $error("zero t with nonzero distance");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff && !eng_valid)
      else $error("response register not loaded after handoff");

endmodule

FILE: rtl/crth_vtx_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crth_vtx_mem
// Vertex table: one row of x, y, z per vertex, registered read.
// ----------------------------------------------------------------------------
module crth_vtx_mem (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [crth_pkg::ADDR_W-1:0] wr_addr,
   input  logic [crth_pkg::ROW_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [crth_pkg::ADDR_W-1:0] rd_addr,
   output logic [crth_pkg::ROW_W-1:0]  rd_data
);
   import crth_pkg::*;

   logic [ROW_W-1:0] mem [1 << ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/crth_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crth_sqrt
// Direction length: sum of squares, then a two-bits-per-step integer root.
// ----------------------------------------------------------------------------
module crth_sqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  crth_pkg::vec3_type       dir,
   output logic                     done,
   output logic [crth_pkg::CW-1:0]  root
);
   import crth_pkg::*;

   localparam int SQ_W  = 2 * CW;
   localparam int LAST  = 3 + CW;

   logic [5:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [SQ_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0] prod_ff, prod_in;
   logic [CW+1:0]   rem_ff, rem_in;
   logic [CW-1:0]   root_ff, root_in;
   logic [CW+3:0]   r2;
   logic [CW+3:0]   trial;
   logic signed [SQ_W-1:0] sq;

   always_comb begin
      sq      = $signed(dir[cnt_ff[1:0]]) * $signed(dir[cnt_ff[1:0]]);
      r2      = {rem_ff, sum_ff[SQ_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      sum_in  = sum_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
         sum_in  = '0;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff < 6'd3) begin
            prod_in = SQ_W'(sq);
         end
         if (cnt_ff >= 6'd1 && cnt_ff <= 6'd3) begin
            sum_in = sum_ff + prod_ff;
         end
         if (cnt_ff >= 6'd4) begin
            sum_in = {sum_ff[SQ_W-3:0], 2'b00};
            if (r2 >= trial) begin
               rem_in  = (CW+2)'(r2 - trial);
               root_in = {root_ff[CW-2:0], 1'b1};
            end else begin
               rem_in  = (CW+2)'(r2);
               root_in = {root_ff[CW-2:0], 1'b0};
            end
            if (cnt_ff == 6'(LAST)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: rtl/crth_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crth_engine
// Triangle walk: fetch, Cramer determinants on a shared multiplier,
// restoring divide for t, closest-hit pick and hit position/distance.
// ----------------------------------------------------------------------------
module crth_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  crth_pkg::trace_type         trc,
   input  logic                        take,
   output logic                        idle,
   output logic                        res_valid,
   output crth_pkg::res_type           res,
   output logic                        rd_en,
   output logic [crth_pkg::ADDR_W-1:0] rd_addr,
   input  logic [crth_pkg::ROW_W-1:0]  rd_data
);
   import crth_pkg::*;

   eng_state_type state_ff, state_in;

   logic [1:0]       a_ff, b_ff;
   logic             h_ff, ph_ff;
   logic [4:0]       dc_ff;
   logic [CNT_W-1:0] i_ff, n_ff;
   logic             found_ff, cand_ff;
   logic [QW-1:0]    best_ff, q_ff, sh_ff;
   logic [TRI_W-1:0] besti_ff;
   vec3_type         dir_ff, org_ff, v0_ff, pos_ff;
   v33_type          nd_ff, e1_ff, e2_ff, bv_ff;
   cr3_type          crc_ff, crp_ff, crq_ff;
   logic signed [DW-1:0] den_ff, nt_ff, nu_ff, nv_ff;
   logic signed [PW-1:0] prod_ff;
   logic [RW-1:0]    rem_ff;
   logic [QW-1:0]    dist_ff;

   logic             sq_done;
   logic [CW-1:0]    sq_root;
   logic signed [MW-1:0] opa, opb;
   logic signed [PW-1:0] prod_in;
   v33_type          va_vec, vb_vec;
   logic [VW-1:0]    xa, xb, xd;
   logic [CRW-1:0]   cs;
   vec3_type         row;
   logic             last_cross, last_dot, last_div, last_tri;
   logic [DW:0]      uvsum;
   logic             test_fail, test_sat;
   logic [RW:0]      r2;
   logic             r2_ge;
   logic signed [DW-1:0] pe, term;
   logic signed [55:0]   psum;
   logic [PW-17:0]   dq;

   crth_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (trc.start),
      .dir   (dir_ff),
      .done  (sq_done),
      .root  (sq_root)
   );

   assign row        = vec3_type'(rd_data);
   assign last_cross = (a_ff == 2'd2) && (b_ff == 2'd2) && h_ff && ph_ff;
   assign last_dot   = (a_ff == 2'd3) && (b_ff == 2'd2) && h_ff && ph_ff;
   assign last_div   = (dc_ff == 5'd0);
   assign last_tri   = ((i_ff + CNT_W'(1)) == n_ff);
   assign uvsum      = {nu_ff[DW-1], nu_ff} + {nv_ff[DW-1], nv_ff};
   assign test_fail  = nt_ff[DW-1] || nu_ff[DW-1] || nv_ff[DW-1] ||
                       ($signed(uvsum) > $signed({1'b0, den_ff}));
   assign test_sat   = {15'b0, nt_ff[DW-1:15]} >= den_ff;
   assign r2         = {rem_ff, sh_ff[QW-1]};
   assign r2_ge      = r2 >= {2'b00, den_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (trc.start) begin
               state_in = (trc.count == '0) ? E_FIN : E_LOAD;
            end
         end
         E_LOAD:  if (a_ff == 2'd3) state_in = E_CROSS;
         E_CROSS: if (last_cross) state_in = E_DOT;
         E_DOT:   if (last_dot) state_in = E_NORM;
         E_NORM:  state_in = (den_ff == '0) ? E_NEXT : E_TEST;
         E_TEST:  state_in = (test_fail || test_sat) ? E_NEXT : E_DIV;
         E_DIV:   if (last_div) state_in = E_NEXT;
         E_NEXT:  state_in = last_tri ? E_FIN : E_LOAD;
         E_FIN: begin
            if (!found_ff || (a_ff == 2'd3 && ph_ff)) begin
               state_in = E_OUT;
            end
         end
         E_OUT:   if (take) state_in = E_IDLE;
         default: state_in = E_IDLE;
      endcase
   end

   // outputs and multiplier operands
   always_comb begin
      idle      = (state_ff == E_IDLE);
      res_valid = (state_ff == E_OUT);
      rd_en     = (state_ff == E_LOAD) && (a_ff != 2'd3);
      rd_addr   = {i_ff[TRI_W-1:0], a_ff};
      va_vec    = e1_ff;
      vb_vec    = e2_ff;
      case (a_ff)
         2'd1:    begin va_vec = e2_ff; vb_vec = nd_ff; end
         2'd2:    begin va_vec = nd_ff; vb_vec = e1_ff; end
         default: begin va_vec = e1_ff; vb_vec = e2_ff; end
      endcase
      xa = h_ff ? va_vec[idx_prev(b_ff)] : va_vec[idx_next(b_ff)];
      xb = h_ff ? vb_vec[idx_next(b_ff)] : vb_vec[idx_prev(b_ff)];
      xd = (a_ff == 2'd0) ? nd_ff[b_ff] : bv_ff[b_ff];
      case (a_ff)
         2'd0, 2'd1: cs = crc_ff[b_ff];
         2'd2:       cs = crp_ff[b_ff];
         default:    cs = crq_ff[b_ff];
      endcase
      opa = '0;
      opb = '0;
      case (state_ff)
         E_CROSS: begin
            opa = MW'($signed(xa));
            opb = MW'($signed(xb));
         end
         E_DOT: begin
            opa = MW'($signed(xd));
            opb = h_ff ? MW'($signed(cs[CRW-1:CRLO])) : {1'b0, cs[CRLO-1:0]};
         end
         E_FIN: begin
            opa = {{(MW-QW){1'b0}}, best_ff};
            opb = (a_ff == 2'd3) ? {{(MW-CW){1'b0}}, sq_root}
                                 : MW'($signed(dir_ff[a_ff]));
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
      prod_in = opa * opb;
      pe      = DW'(prod_ff);
      term    = h_ff ? (pe <<< CRLO) : pe;
      psum    = 56'(prod_ff >>> FRAC) + 56'($signed(org_ff[a_ff]));
      dq      = prod_ff[PW-1:FRAC];
      res.hit       = found_ff;
      res.hit_tri   = found_ff ? besti_ff : '0;
      res.hit_param = found_ff ? best_ff : '0;
      res.pos_x     = found_ff ? pos_ff[0] : '0;
      res.pos_y     = found_ff ? pos_ff[1] : '0;
      res.pos_z     = found_ff ? pos_ff[2] : '0;
      res.hit_dist  = found_ff ? dist_ff : '0;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         a_ff     <= '0;
         b_ff     <= '0;
         h_ff     <= 1'b0;
         ph_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_in != state_ff) begin
            a_ff  <= '0;
            b_ff  <= '0;
            h_ff  <= 1'b0;
            ph_ff <= 1'b0;
         end else if (state_ff == E_LOAD) begin
            a_ff <= a_ff + 2'd1;
         end else if (state_ff == E_CROSS || state_ff == E_DOT) begin
            ph_ff <= !ph_ff;
            if (ph_ff) begin
               h_ff <= !h_ff;
               if (h_ff) begin
                  b_ff <= (b_ff == 2'd2) ? 2'd0 : b_ff + 2'd1;
                  if (b_ff == 2'd2) a_ff <= a_ff + 2'd1;
               end
            end
         end else if (state_ff == E_FIN && found_ff && sq_done) begin
            ph_ff <= !ph_ff;
            if (ph_ff) a_ff <= a_ff + 2'd1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (!ph_ff) prod_ff <= prod_in;
      if (reset) begin
         found_ff <= 1'b0;
         cand_ff  <= 1'b0;
      end else begin
         case (state_ff)
            E_IDLE: begin
               if (trc.start) begin
                  dir_ff   <= trc.dir;
                  org_ff   <= trc.org;
                  n_ff     <= (trc.count > TRI_LIMIT) ? TRI_LIMIT : trc.count;
                  i_ff     <= '0;
                  best_ff  <= TMAX;
                  besti_ff <= '0;
                  found_ff <= 1'b0;
                  for (int k = 0; k < 3; k++) begin
                     nd_ff[k] <= -VW'($signed(trc.dir[k]));
                  end
               end
            end
            E_LOAD: begin
               for (int k = 0; k < 3; k++) begin
                  if (a_ff == 2'd1) begin
                     v0_ff[k] <= row[k];
                     bv_ff[k] <= VW'($signed(org_ff[k])) - VW'($signed(row[k]));
                  end
                  if (a_ff == 2'd2)
                     e1_ff[k] <= VW'($signed(row[k])) - VW'($signed(v0_ff[k]));
                  if (a_ff == 2'd3)
                     e2_ff[k] <= VW'($signed(row[k])) - VW'($signed(v0_ff[k]));
               end
            end
            E_CROSS: begin
               if (ph_ff) begin
                  case (a_ff)
                     2'd0: crc_ff[b_ff] <= h_ff ? crc_ff[b_ff] - prod_ff[CRW-1:0]
                                                : prod_ff[CRW-1:0];
                     2'd1: crp_ff[b_ff] <= h_ff ? crp_ff[b_ff] - prod_ff[CRW-1:0]
                                                : prod_ff[CRW-1:0];
                     default: crq_ff[b_ff] <= h_ff ? crq_ff[b_ff] - prod_ff[CRW-1:0]
                                                   : prod_ff[CRW-1:0];
                  endcase
               end
            end
            E_DOT: begin
               if (ph_ff) begin
                  case (a_ff)
                     2'd0: den_ff <= (b_ff == 2'd0 && !h_ff) ? term : den_ff + term;
                     2'd1: nt_ff  <= (b_ff == 2'd0 && !h_ff) ? term : nt_ff + term;
                     2'd2: nu_ff  <= (b_ff == 2'd0 && !h_ff) ? term : nu_ff + term;
                     default: nv_ff <= (b_ff == 2'd0 && !h_ff) ? term : nv_ff + term;
                  endcase
               end
            end
            E_NORM: begin
               cand_ff <= 1'b0;
               if (den_ff[DW-1]) begin
                  den_ff <= -den_ff;
                  nt_ff  <= -nt_ff;
                  nu_ff  <= -nu_ff;
                  nv_ff  <= -nv_ff;
               end
            end
            E_TEST: begin
               cand_ff <= !test_fail;
               q_ff    <= test_sat ? TMAX : '0;
               rem_ff  <= {15'b0, nt_ff[DW-1:15]};
               sh_ff   <= {nt_ff[14:0], 16'b0};
               dc_ff   <= 5'd30;
            end
            E_DIV: begin
               rem_ff <= r2_ge ? RW'(r2 - {2'b00, den_ff}) : RW'(r2);
               q_ff   <= {q_ff[QW-2:0], r2_ge};
               sh_ff  <= {sh_ff[QW-2:0], 1'b0};
               dc_ff  <= dc_ff - 5'd1;
            end
            E_NEXT: begin
               if (cand_ff && q_ff <= best_ff) begin
                  found_ff <= 1'b1;
                  best_ff  <= q_ff;
                  besti_ff <= i_ff[TRI_W-1:0];
               end
               i_ff <= i_ff + CNT_W'(1);
            end
            E_FIN: begin
               if (ph_ff) begin
                  if (a_ff == 2'd3) begin
                     dist_ff <= (|dq[PW-17:QW]) ? TMAX : dq[QW-1:0];
                  end else if (psum > 56'sd2147483647) begin
                     pos_ff[a_ff] <= 32'h7FFF_FFFF;
                  end else if (psum < -56'sd2147483648) begin
                     pos_ff[a_ff] <= 32'h8000_0000;
                  end else begin
                     pos_ff[a_ff] <= psum[CW-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule
